### rtl/mcb_pkg.sv
// shared types and constants for the mesh chunk builder
// used by the cell row and the top level; no dependencies

package mcb_pkg;

  localparam int LIMIT_W = 8;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd128;
  localparam int LIMIT_FLOOR = 3;

  // register index decoded from the apb address
  localparam logic REG_LIMIT = 1'b0;
  localparam logic REG_VCOUNT = 1'b1;

  typedef enum logic [1:0] {
    SHIFT_0 = 2'd0,
    SHIFT_1 = 2'd1,
    SHIFT_2 = 2'd2,
    SHIFT_3 = 2'd3
  } shift_t;

  typedef struct packed {
    logic   load;
    shift_t shift;
  } cell_ctrl_t;

endpackage

### rtl/mcb_if.sv
// word channels of the mesh chunk builder: face input and chunk result
// no dependencies

interface mcb_face_if #(
  parameter int INDEX_BITS = 24
) ();
  logic                  valid;
  logic                  ready;
  logic                  run_start;
  logic [INDEX_BITS-1:0] face_index;
  logic [INDEX_BITS-1:0] corner_a;
  logic [INDEX_BITS-1:0] corner_b;
  logic [INDEX_BITS-1:0] corner_c;
  logic                  positions_finite;

  modport source (
    output valid, run_start, face_index, corner_a, corner_b, corner_c, positions_finite,
    input  ready
  );
  modport sink (
    input  valid, run_start, face_index, corner_a, corner_b, corner_c, positions_finite,
    output ready
  );
endinterface

interface mcb_result_if #(
  parameter int INDEX_BITS = 24,
  parameter int LOCAL_W = 7,
  parameter int VCNT_W = 8,
  parameter int FACE_W = 9
) ();
  logic                  valid;
  logic                  ready;
  logic                  skipped;
  logic                  opened_chunk;
  logic [INDEX_BITS-1:0] chunk_first_face;
  logic [LOCAL_W-1:0]    local_a;
  logic [LOCAL_W-1:0]    local_b;
  logic [LOCAL_W-1:0]    local_c;
  logic [2:0]            new_slots;
  logic [VCNT_W-1:0]     chunk_vertices;
  logic [FACE_W-1:0]     chunk_faces;

  modport source (
    output valid, skipped, opened_chunk, chunk_first_face, local_a, local_b, local_c,
           new_slots, chunk_vertices, chunk_faces,
    input  ready
  );
  modport sink (
    input  valid, skipped, opened_chunk, chunk_first_face, local_a, local_b, local_c,
           new_slots, chunk_vertices, chunk_faces,
    output ready
  );
endinterface

### rtl/mcb_cell.sv
// one entry of the vertex map row: holds a global index, compares it with
// the three corners and takes a neighbor's entry when new vertices shift in
// depends on mcb_pkg

module mcb_cell import mcb_pkg::*; #(
  parameter int INDEX_BITS = 24
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [INDEX_BITS-1:0] src1,
  input  logic [INDEX_BITS-1:0] src2,
  input  logic [INDEX_BITS-1:0] src3,
  input  logic                  in_use,
  input  logic [INDEX_BITS-1:0] corner_a,
  input  logic [INDEX_BITS-1:0] corner_b,
  input  logic [INDEX_BITS-1:0] corner_c,
  output logic [INDEX_BITS-1:0] entry,
  output logic [2:0]            hit
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      case (ctrl.shift)
        SHIFT_1: entry <= src1;
        SHIFT_2: entry <= src2;
        SHIFT_3: entry <= src3;
        default: entry <= entry;
      endcase
    end
  end

  assign hit[0] = in_use && (entry == corner_a);
  assign hit[1] = in_use && (entry == corner_b);
  assign hit[2] = in_use && (entry == corner_c);

endmodule

### rtl/mcb_hit_encoder.sv
// turns one corner's hit vector over the cell row into a found flag and
// the local slot of the matching entry (newest entry sits in cell 0)
// no dependencies

module mcb_hit_encoder #(
  parameter int CELLS = 128,
  parameter int LOCAL_W = 7,
  parameter int VCNT_W = 8
) (
  input  logic [CELLS-1:0]  hit,
  input  logic [VCNT_W-1:0] map_used,
  output logic              found,
  output logic [LOCAL_W-1:0] slot
);

  logic [LOCAL_W-1:0] pos;

  always_comb begin
    pos = '0;
    for (int p = 0; p < CELLS; p++) begin
      if (hit[p]) begin
        pos = pos | LOCAL_W'(p);
      end
    end
  end

  assign found = |hit;
  assign slot = LOCAL_W'(map_used - VCNT_W'(1) - VCNT_W'(pos));

endmodule

### rtl/mesh_chunk_builder.sv
// top level of the mesh chunk builder: apb registers, face pipeline,
// chunk state and the row of map cells
// depends on mcb_pkg, mcb_if, mcb_cell, mcb_hit_encoder

// Takes one face word per cycle unless results stall and returns one result
// word per face; while a result stalls, one more face can enter and wait in
// the input stage. The rate is set by the vertex map: a row of
// cells, each holding one local vertex, compares all three corners in the
// same cycle and new vertices shift into the row from its head, up to three
// per face. A face is skipped when a corner is at or above mesh_vertex_count
// or its positions are not finite. No clearing pass is needed after reset;
// the map is empty as soon as reset is released. Registers:
// chunk_vertex_limit at byte address 0 (clamped to 3..MAX_CHUNK_VERTICES),
// mesh_vertex_count at address 4; write them only while no face is in flight.

module mesh_chunk_builder import mcb_pkg::*; #(
  parameter int MAX_CHUNK_VERTICES = 128,
  parameter int INDEX_BITS = 24,
  localparam int MCOUNT_W = INDEX_BITS + 1,
  localparam int PDATA_W = (MCOUNT_W > 32) ? 64 : 32,
  localparam int ADDR_LSB = (PDATA_W == 64) ? 3 : 2,
  localparam int PADDR_W = ADDR_LSB + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  mcb_face_if.sink           faces,
  mcb_result_if.source       results
);

  localparam int CELLS = MAX_CHUNK_VERTICES;
  localparam int LOCAL_W = $clog2(CELLS);
  localparam int VCNT_W = $clog2(CELLS + 1);
  localparam int FACE_W = $clog2(2 * CELLS + 1);
  localparam int CMP_W = ((LIMIT_W > FACE_W) ? LIMIT_W : FACE_W) + 1;

  // configuration registers
  logic [LIMIT_W-1:0]  chunk_vertex_limit;
  logic [MCOUNT_W-1:0] mesh_vertex_count;
  logic                cfg_write;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_vertex_limit <= LIMIT_RESET;
      mesh_vertex_count <= '0;
    end else if (cfg_write) begin
      case (paddr[ADDR_LSB])
        REG_LIMIT:  chunk_vertex_limit <= pwdata[LIMIT_W-1:0];
        REG_VCOUNT: mesh_vertex_count <= pwdata[MCOUNT_W-1:0];
        default:    chunk_vertex_limit <= chunk_vertex_limit;
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_LSB])
      REG_LIMIT:  prdata = PDATA_W'(chunk_vertex_limit);
      REG_VCOUNT: prdata = PDATA_W'(mesh_vertex_count);
      default:    prdata = '0;
    endcase
  end

  // input stage
  logic                  s1_valid;
  logic                  s1_run_start;
  logic                  s1_ok;
  logic [INDEX_BITS-1:0] s1_face;
  logic [INDEX_BITS-1:0] s1_a;
  logic [INDEX_BITS-1:0] s1_b;
  logic [INDEX_BITS-1:0] s1_c;
  logic                  out_free;
  logic                  advance;
  logic                  take;
  logic                  face_ok;

  assign out_free = !results.valid || results.ready;
  assign advance = s1_valid && out_free;
  assign faces.ready = !s1_valid || out_free;
  assign take = faces.valid && faces.ready;
  assign face_ok = faces.positions_finite
                   && (MCOUNT_W'(faces.corner_a) < mesh_vertex_count)
                   && (MCOUNT_W'(faces.corner_b) < mesh_vertex_count)
                   && (MCOUNT_W'(faces.corner_c) < mesh_vertex_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_run_start <= faces.run_start;
      s1_ok <= face_ok;
      s1_face <= faces.face_index;
      s1_a <= faces.corner_a;
      s1_b <= faces.corner_b;
      s1_c <= faces.corner_c;
    end
  end

  // chunk state
  logic [VCNT_W-1:0]     map_used;
  logic [FACE_W-1:0]     face_count;
  logic                  need_new_chunk;
  logic [INDEX_BITS-1:0] pending_start_face;
  logic [INDEX_BITS-1:0] current_first_face;

  // cell row
  logic [INDEX_BITS-1:0] chain [CELLS+3];
  logic [CELLS-1:0]      hit_a;
  logic [CELLS-1:0]      hit_b;
  logic [CELLS-1:0]      hit_c;
  cell_ctrl_t            cell_ctrl;
  logic [INDEX_BITS-1:0] ins0;
  logic [INDEX_BITS-1:0] ins1;

  assign chain[0] = s1_c;
  assign chain[1] = ins1;
  assign chain[2] = ins0;

  for (genvar p = 0; p < CELLS; p++) begin : g_cell
    logic [2:0] hit;

    mcb_cell #(
      .INDEX_BITS(INDEX_BITS)
    ) u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .src1     (chain[p+2]),
      .src2     (chain[p+1]),
      .src3     (chain[p]),
      .in_use   (VCNT_W'(p) < map_used),
      .corner_a (s1_a),
      .corner_b (s1_b),
      .corner_c (s1_c),
      .entry    (chain[p+3]),
      .hit      (hit)
    );

    assign hit_a[p] = hit[0];
    assign hit_b[p] = hit[1];
    assign hit_c[p] = hit[2];
  end

  logic               found_a;
  logic               found_b;
  logic               found_c;
  logic [LOCAL_W-1:0] slot_a;
  logic [LOCAL_W-1:0] slot_b;
  logic [LOCAL_W-1:0] slot_c;

  mcb_hit_encoder #(.CELLS(CELLS), .LOCAL_W(LOCAL_W), .VCNT_W(VCNT_W)) u_enc_a (
    .hit(hit_a), .map_used(map_used), .found(found_a), .slot(slot_a)
  );
  mcb_hit_encoder #(.CELLS(CELLS), .LOCAL_W(LOCAL_W), .VCNT_W(VCNT_W)) u_enc_b (
    .hit(hit_b), .map_used(map_used), .found(found_b), .slot(slot_b)
  );
  mcb_hit_encoder #(.CELLS(CELLS), .LOCAL_W(LOCAL_W), .VCNT_W(VCNT_W)) u_enc_c (
    .hit(hit_c), .map_used(map_used), .found(found_c), .slot(slot_c)
  );

  // placement decision
  logic                  nn;
  logic [INDEX_BITS-1:0] pend;
  logic [1:0]            added;
  logic [CMP_W-1:0]      limit_ext;
  logic [FACE_W-1:0]     lim;
  logic [FACE_W-1:0]     lim2;
  logic                  overflow;
  logic                  open;
  logic [VCNT_W-1:0]     base;
  logic                  ha;
  logic                  hb;
  logic                  hc;
  logic                  na;
  logic                  nb;
  logic                  nc;
  logic [LOCAL_W-1:0]    la;
  logic [LOCAL_W-1:0]    lb;
  logic [LOCAL_W-1:0]    lc;
  logic [1:0]            k;
  logic [VCNT_W-1:0]     used_next;
  logic [FACE_W-1:0]     faces_next;
  logic [INDEX_BITS-1:0] first_next;

  always_comb begin
    nn = need_new_chunk || s1_run_start;
    pend = s1_run_start ? s1_face : pending_start_face;
    added = 2'(!found_a) + 2'(!found_b) + 2'(!found_c);

    limit_ext = CMP_W'(chunk_vertex_limit);
    if (limit_ext < CMP_W'(LIMIT_FLOOR)) begin
      lim = FACE_W'(LIMIT_FLOOR);
    end else if (limit_ext > CMP_W'(CELLS)) begin
      lim = FACE_W'(CELLS);
    end else begin
      lim = limit_ext[FACE_W-1:0];
    end
    lim2 = {lim[FACE_W-2:0], 1'b0};

    overflow = !nn && (((FACE_W+1)'(map_used) + (FACE_W+1)'(added) > (FACE_W+1)'(lim))
                       || (face_count >= lim2));
    open = nn || overflow;
    base = open ? '0 : map_used;

    ha = found_a && !open;
    hb = found_b && !open;
    hc = found_c && !open;

    na = !ha;
    la = ha ? slot_a : LOCAL_W'(base);

    nb = !hb && (s1_b != s1_a);
    if (hb) begin
      lb = slot_b;
    end else if (s1_b == s1_a) begin
      lb = la;
    end else begin
      lb = LOCAL_W'(base + VCNT_W'(na));
    end

    nc = !hc && (s1_c != s1_a) && (s1_c != s1_b);
    if (hc) begin
      lc = slot_c;
    end else if (s1_c == s1_a) begin
      lc = la;
    end else if (s1_c == s1_b) begin
      lc = lb;
    end else begin
      lc = LOCAL_W'(base + VCNT_W'(na) + VCNT_W'(nb));
    end

    k = 2'(na) + 2'(nb) + 2'(nc);
    ins0 = na ? s1_a : (nb ? s1_b : s1_c);
    ins1 = (na && nb) ? s1_b : s1_c;

    used_next = base + VCNT_W'(k);
    faces_next = (open ? '0 : face_count) + FACE_W'(1);
    first_next = open ? (nn ? pend : s1_face) : current_first_face;
  end

  assign cell_ctrl.load = advance && s1_ok;
  assign cell_ctrl.shift = shift_t'(k);

  always_ff @(posedge clk) begin
    if (rst) begin
      map_used <= '0;
      face_count <= '0;
      need_new_chunk <= 1'b1;
      pending_start_face <= '0;
      current_first_face <= '0;
    end else if (advance) begin
      pending_start_face <= pend;
      if (s1_ok) begin
        map_used <= used_next;
        face_count <= faces_next;
        need_new_chunk <= 1'b0;
        current_first_face <= first_next;
      end else begin
        need_new_chunk <= nn;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (advance) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      results.skipped <= !s1_ok;
      if (s1_ok) begin
        results.opened_chunk <= open;
        results.chunk_first_face <= first_next;
        results.local_a <= la;
        results.local_b <= lb;
        results.local_c <= lc;
        results.new_slots <= {nc, nb, na};
        results.chunk_vertices <= used_next;
        results.chunk_faces <= faces_next;
      end else begin
        results.opened_chunk <= 1'b0;
        results.chunk_first_face <= current_first_face;
        results.local_a <= '0;
        results.local_b <= '0;
        results.local_c <= '0;
        results.new_slots <= '0;
        results.chunk_vertices <= map_used;
        results.chunk_faces <= face_count;
      end
    end
  end

endmodule

### test/mcb_chunk_checker.sv
`timescale 1ns / 100ps
// chunk checker for mesh_chunk_builder: watches the apb writes and both word
// channels, predicts each chunk word and compares it field by field
// depends on mcb_pkg and the channel interfaces in mcb_if

module mcb_chunk_checker import mcb_pkg::*; #(
  parameter int MAX_CHUNK_VERTICES = 128,
  parameter int INDEX_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  mcb_face_if         faces,
  mcb_result_if       results,
  output int          mismatches,
  output int          in_flight,
  output int          faces_checked,
  output int          faces_skipped,
  output int          chunks_opened
);

  typedef struct packed {
    logic                  skipped;
    logic                  opened;
    logic [INDEX_BITS-1:0] head_face;
    logic [6:0]            loc_a;
    logic [6:0]            loc_b;
    logic [6:0]            loc_c;
    logic [2:0]            fresh;
    logic [7:0]            verts;
    logic [8:0]            nfaces;
  } chunk_word_t;

  chunk_word_t due_chunks[$];

  logic [INDEX_BITS-1:0] vmap [MAX_CHUNK_VERTICES];
  int                    used;
  int                    face_total;
  logic                  reopen;
  logic [INDEX_BITS-1:0] start_face;
  logic [INDEX_BITS-1:0] chunk_head;
  logic [7:0]            vlimit;
  logic [24:0]           vcount;

  function automatic int slot_of(logic [INDEX_BITS-1:0] g);
    for (int i = 0; i < used && i < MAX_CHUNK_VERTICES; i++) begin
      if (vmap[i] == g) return i;
    end
    return -1;
  endfunction

  function automatic chunk_word_t place_face(logic rs, logic [INDEX_BITS-1:0] fi,
                                             logic [INDEX_BITS-1:0] ca,
                                             logic [INDEX_BITS-1:0] cb,
                                             logic [INDEX_BITS-1:0] cc, logic fin);
    logic [INDEX_BITS-1:0] corner [3];
    int                    loc [3];
    chunk_word_t           w;
    int                    lim;
    int                    added;
    int                    hit;
    logic                  ok;
    corner[0] = ca;
    corner[1] = cb;
    corner[2] = cc;
    loc = '{0, 0, 0};
    w = '0;
    if (rs) begin
      reopen = 1'b1;
      start_face = fi;
    end
    ok = fin;
    for (int j = 0; j < 3; j++) begin
      if ({1'b0, corner[j]} >= vcount) ok = 1'b0;
    end
    if (ok) begin
      lim = vlimit;
      if (lim < LIMIT_FLOOR) lim = LIMIT_FLOOR;
      if (lim > MAX_CHUNK_VERTICES) lim = MAX_CHUNK_VERTICES;
      added = 0;
      for (int j = 0; j < 3; j++) begin
        if (slot_of(corner[j]) < 0) added++;
      end
      // duplicate corners count once per occurrence here
      if (!reopen && (used + added > lim || face_total >= 2 * lim)) begin
        reopen = 1'b1;
        start_face = fi;
      end
      if (reopen) begin
        chunk_head = start_face;
        used = 0;
        face_total = 0;
        reopen = 1'b0;
        w.opened = 1'b1;
      end
      for (int j = 0; j < 3; j++) begin
        hit = slot_of(corner[j]);
        if (hit >= 0) begin
          loc[j] = hit;
        end else if (used < MAX_CHUNK_VERTICES) begin
          vmap[used] = corner[j];
          loc[j] = used;
          used++;
          w.fresh[j] = 1'b1;
        end
      end
      face_total++;
    end
    w.skipped = !ok;
    w.head_face = chunk_head;
    w.loc_a = loc[0][6:0];
    w.loc_b = loc[1][6:0];
    w.loc_c = loc[2][6:0];
    w.verts = used[7:0];
    w.nfaces = face_total[8:0];
    return w;
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t chunk word %0d: %s expected %0h got %0h",
                 $time, faces_checked, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    chunk_word_t want;
    if (rst) begin
      due_chunks.delete();
      used = 0;
      face_total = 0;
      reopen = 1'b1;
      start_face = '0;
      chunk_head = '0;
      vlimit = LIMIT_RESET;
      vcount = '0;
      mismatches = 0;
      faces_checked = 0;
      faces_skipped = 0;
      chunks_opened = 0;
    end else begin
      if (results.valid && results.ready) begin
        if (due_chunks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t chunk word with no face pending", $time);
        end else begin
          want = due_chunks.pop_front();
          check_field("skipped", want.skipped, results.skipped);
          check_field("opened_chunk", want.opened, results.opened_chunk);
          check_field("chunk_first_face", want.head_face, results.chunk_first_face);
          check_field("local_a", want.loc_a, results.local_a);
          check_field("local_b", want.loc_b, results.local_b);
          check_field("local_c", want.loc_c, results.local_c);
          check_field("new_slots", want.fresh, results.new_slots);
          check_field("chunk_vertices", want.verts, results.chunk_vertices);
          check_field("chunk_faces", want.nfaces, results.chunk_faces);
          faces_checked++;
          if (want.skipped) faces_skipped++;
          if (want.opened) chunks_opened++;
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_LIMIT) vlimit = pwdata[7:0];
        else vcount = pwdata[24:0];
      end
      if (faces.valid && faces.ready)
        due_chunks.insert(due_chunks.size(),
                          place_face(faces.run_start, faces.face_index, faces.corner_a,
                                     faces.corner_b, faces.corner_c,
                                     faces.positions_finite));
    end
    in_flight = due_chunks.size();
  end

endmodule

### test/tb_mesh_chunk_builder.sv
`timescale 1ns / 100ps
// testbench top for mesh_chunk_builder: clock, reset, register writes, face
// words in bursts and result back-pressure; the verdict comes from mcb_chunk_checker
// depends on mcb_pkg, mcb_if, mcb_chunk_checker and the rtl

module tb_mesh_chunk_builder import mcb_pkg::*; ();

  localparam int MAX_CHUNK_VERTICES = 128;
  localparam int INDEX_BITS = 24;
  localparam int RANDOM_FACES = 900;

  typedef enum logic [1:0] {RX_OPEN, RX_SPARSE, RX_PERIODIC, RX_CHOKED} rx_mode_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic        pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;

  int mismatches;
  int in_flight;
  int faces_checked;
  int faces_skipped;
  int chunks_opened;
  int faces_sent = 0;
  int burst_left = 0;
  int settings_used = 0;
  int rx_left = 0;
  rx_mode_t rx_mode = RX_OPEN;

  logic [7:0] limit_pick [9] = '{8'd3, 8'd128, 8'd0, 8'd255, 8'd1, 8'd2, 8'd129, 8'd4, 8'd64};

  mcb_face_if #(.INDEX_BITS(INDEX_BITS)) face_ch ();
  mcb_result_if #(.INDEX_BITS(INDEX_BITS)) res_ch ();

  mesh_chunk_builder #(
    .MAX_CHUNK_VERTICES(MAX_CHUNK_VERTICES),
    .INDEX_BITS(INDEX_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .faces(face_ch),
    .results(res_ch)
  );

  mcb_chunk_checker #(
    .MAX_CHUNK_VERTICES(MAX_CHUNK_VERTICES),
    .INDEX_BITS(INDEX_BITS)
  ) chunk_check (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .pready(pready),
    .paddr(paddr),
    .pwdata(pwdata),
    .faces(face_ch),
    .results(res_ch),
    .mismatches(mismatches),
    .in_flight(in_flight),
    .faces_checked(faces_checked),
    .faces_skipped(faces_skipped),
    .chunks_opened(chunks_opened)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result back-pressure
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(4, 48);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN: res_ch.ready <= 1'b1;
      RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: res_ch.ready <= rx_left[2];
      default: res_ch.ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  function automatic logic [INDEX_BITS-1:0] rand_index();
    return INDEX_BITS'($urandom_range(0, 24'hFFFFFF));
  endfunction

  function automatic logic [INDEX_BITS-1:0] pick_corner(int base, int pool, int vcnt);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 92) return INDEX_BITS'(base + $urandom_range(0, pool - 1));
    if (roll < 95) return INDEX_BITS'(vcnt - 1);
    if (roll < 97 && vcnt <= 24'hFFFFFF) return INDEX_BITS'(vcnt);
    return rand_index();
  endfunction

  task automatic push_face(logic rs, logic [INDEX_BITS-1:0] fi, logic [INDEX_BITS-1:0] ca,
                           logic [INDEX_BITS-1:0] cb, logic [INDEX_BITS-1:0] cc, logic fin);
    face_ch.valid = 1'b1;
    face_ch.run_start = rs;
    face_ch.face_index = fi;
    face_ch.corner_a = ca;
    face_ch.corner_b = cb;
    face_ch.corner_c = cc;
    face_ch.positions_finite = fin;
    @(posedge clk);
    while (!face_ch.ready) @(posedge clk);
    @(negedge clk);
    faces_sent++;
    if (burst_left == 0) begin
      face_ch.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(20, 60);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    face_ch.valid = 1'b0;
    wait (in_flight == 0);
    @(negedge clk);
  endtask

  task automatic apb_write(logic idx, logic [31:0] val);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic program_chunk(logic [7:0] lim, logic [24:0] vcnt);
    drain();
    apb_write(REG_LIMIT, {24'd0, lim});
    apb_write(REG_VCOUNT, {7'd0, vcnt});
    settings_used++;
  endtask

  initial begin
    int                    random_start;
    int                    ph;
    int                    pool;
    int                    base;
    int                    starts;
    int                    n;
    logic [7:0]            lim;
    logic [24:0]           vcnt;
    logic [INDEX_BITS-1:0] seq;
    logic [INDEX_BITS-1:0] fi;
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    res_ch.ready = 1'b0;
    face_ch.valid = 1'b0;
    face_ch.run_start = 1'b0;
    face_ch.face_index = '0;
    face_ch.corner_a = '0;
    face_ch.corner_b = '0;
    face_ch.corner_c = '0;
    face_ch.positions_finite = 1'b0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // reset settings: no vertex is valid, so the run start is only recorded
    push_face(1'b1, 24'hFFFFFF, 24'd0, 24'd0, 24'd0, 1'b1);
    program_chunk(8'd3, 25'd16);
    push_face(1'b0, 24'd1, 24'd0, 24'd1, 24'd2, 1'b1);
    // face count overflow at twice the limit
    for (int i = 2; i < 8; i++) push_face(1'b0, INDEX_BITS'(i), 24'd2, 24'd1, 24'd0, 1'b1);
    // repeated corner counts three times toward the limit
    push_face(1'b0, 24'd10, 24'd3, 24'd3, 24'd3, 1'b1);
    push_face(1'b0, 24'd11, 24'd4, 24'd5, 24'd6, 1'b0);
    push_face(1'b0, 24'd12, 24'd4, 24'd5, 24'd16, 1'b1);
    push_face(1'b1, 24'd13, 24'd15, 24'd14, 24'd3, 1'b1);
    push_face(1'b1, 24'd14, 24'd0, 24'd1, 24'd17, 1'b1);
    push_face(1'b0, 24'd15, 24'd3, 24'd14, 24'd15, 1'b1);
    push_face(1'b0, 24'd16, 24'd3, 24'd4, 24'd5, 1'b1);
    program_chunk(8'd255, 25'h1000000);
    push_face(1'b0, 24'd17, 24'hFFFFFF, 24'd0, 24'h800000, 1'b1);
    push_face(1'b1, 24'h5A5A5A, 24'hFFFFFF, 24'h555555, 24'hAAAAAA, 1'b1);
    program_chunk(8'd0, 25'hFFFFFF);
    push_face(1'b0, 24'd0, 24'hFFFFFF, 24'd1, 24'd2, 1'b1);
    push_face(1'b0, 24'hA5A5A5, 24'hFFFFFE, 24'd1, 24'd2, 1'b1);

    random_start = faces_sent;
    ph = 0;
    while (faces_sent - random_start < RANDOM_FACES) begin
      lim = (ph < 9) ? limit_pick[ph] : 8'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
        0: vcnt = 25'h1000000;
        1: vcnt = 25'($urandom_range(3, 2000));
        2: vcnt = 25'($urandom_range(3, 24'hFFFFFF));
        default: vcnt = 25'h1000000 - 25'($urandom_range(0, 7));
      endcase
      program_chunk(lim, vcnt);
      pool = $urandom_range(0, 1) ? $urandom_range(3, 12) : $urandom_range(3, 300);
      starts = $urandom_range(0, 1) ? 0 : $urandom_range(1, 20);
      n = $urandom_range(40, 200);
      // long run on a few vertices so the face count reaches twice the top limit
      if (ph == 1) begin
        pool = 6;
        starts = 0;
        n = 280;
      end
      if (pool > vcnt) pool = vcnt;
      if (n > RANDOM_FACES - (faces_sent - random_start))
        n = RANDOM_FACES - (faces_sent - random_start);
      base = $urandom_range(0, vcnt - pool);
      seq = rand_index();
      repeat (n) begin
        fi = ($urandom_range(0, 7) == 0) ? rand_index() : seq;
        seq++;
        push_face($urandom_range(0, 99) < starts, fi, pick_corner(base, pool, vcnt),
                  pick_corner(base, pool, vcnt), pick_corner(base, pool, vcnt),
                  $urandom_range(0, 99) >= 4);
      end
      ph++;
    end

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d faces over %0d register settings: %0d skipped, %0d chunks opened",
             faces_checked, settings_used, faces_skipped, chunks_opened);
    if (mismatches == 0 && in_flight == 0) begin
      $display("tb_mesh_chunk_builder OK");
    end else begin
      $display("tb_mesh_chunk_builder NOT OK");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("timeout with %0d words outstanding", in_flight);
    $display("tb_mesh_chunk_builder NOT OK");
    $finish;
  end

endmodule
